/* rtl/triangle_face_normal_unit_assert.svh */
// Assertion macros for the triangle face normal unit.
// Each macro is a clocked implication with an asynchronous low reset disable.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH

`ifndef SYNTH

// same-cycle implication
`define TFN_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define TFN_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`else

`define TFN_ASSERT_IMP(lbl, ck, rn, ante, cons)
`define TFN_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

/* rtl/tfn_pkg.sv */
// ----------------------------------------------------------------------------
// tfn_pkg
// Types, codes and helpers shared by the triangle face normal unit.
// ----------------------------------------------------------------------------
package tfn_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FACE  = 1'b1;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_X = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_Y = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_FALLBACK_Z = 2'd2;

	localparam int COORD_W = 16;
	localparam int IDX_W   = 10;
	localparam int VTX_W   = 3 * COORD_W;
	localparam int MAG_W   = 34;   // |cross component| < 2^33
	localparam int SQ_W    = 66;   // square of a magnitude
	localparam int NRM2_W  = 68;   // sum of three squares
	localparam int ROOT_W  = 15;   // 0..16384

	typedef struct packed {
		logic                      operation;
		logic [IDX_W-1:0]          vertex_slot;
		logic signed [COORD_W-1:0] coord_x;
		logic signed [COORD_W-1:0] coord_y;
		logic signed [COORD_W-1:0] coord_z;
		logic [IDX_W-1:0]          corner_a;
		logic [IDX_W-1:0]          corner_b;
		logic [IDX_W-1:0]          corner_c;
	} req_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] normal_x;
		logic signed [COORD_W-1:0] normal_y;
		logic signed [COORD_W-1:0] normal_z;
		logic                      degenerate;
	} result_t;

	// norm unit handshake
	typedef struct packed {
		logic                  start;
		logic [SQ_W-1:0]       sq;
		logic [NRM2_W-1:0]     nrm2;
	} norm_req_t;

	typedef struct packed {
		logic                  done;
		logic [ROOT_W-1:0]     root;
	} norm_rsp_t;

	// square step: which component and which partial product
	typedef struct packed {
		logic [1:0] comp;
		logic [1:0] part;
	} sq_sel_t;

	function automatic sq_sel_t sq_map(input logic [3:0] j);
		sq_sel_t r;
		case (j)
			4'd0: r = '{comp: 2'd0, part: 2'd0};
			4'd1: r = '{comp: 2'd0, part: 2'd1};
			4'd2: r = '{comp: 2'd0, part: 2'd2};
			4'd3: r = '{comp: 2'd1, part: 2'd0};
			4'd4: r = '{comp: 2'd1, part: 2'd1};
			4'd5: r = '{comp: 2'd1, part: 2'd2};
			4'd6: r = '{comp: 2'd2, part: 2'd0};
			4'd7: r = '{comp: 2'd2, part: 2'd1};
			4'd8: r = '{comp: 2'd2, part: 2'd2};
			default: r = '{comp: 2'd0, part: 2'd0};
		endcase
		return r;
	endfunction

endpackage

/* rtl/tfn_ram.sv */
// ----------------------------------------------------------------------------
// tfn_ram
// Generic simple dual-port RAM, one write port, registered read.
// ----------------------------------------------------------------------------
module tfn_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

/* rtl/tfn_norm.sv */
// ----------------------------------------------------------------------------
// tfn_norm
// One normal component: q = isqrt(floor(sq * 2^28 / nrm2)), bit-serial.
// 29 restoring divide steps then 15 square-root steps.
// ----------------------------------------------------------------------------
module tfn_norm (
	input  logic                clk,
	input  logic                arst_n,
	input  tfn_pkg::norm_req_t  nreq,
	output tfn_pkg::norm_rsp_t  nrsp
);
	import tfn_pkg::*;

	localparam logic [1:0] NM_IDLE = 2'd0;
	localparam logic [1:0] NM_DIV  = 2'd1;
	localparam logic [1:0] NM_SQRT = 2'd2;
	localparam int DQ_W  = 29;
	localparam int REM_W = NRM2_W + 1;
	localparam int OP_W  = 30;

	logic [1:0]        st_q;
	logic [4:0]        cnt_q;
	logic [REM_W-1:0]  rem_q;
	logic [NRM2_W-1:0] div_q;
	logic [DQ_W-1:0]   quo_q;
	logic [OP_W-1:0]   op_q;
	logic [OP_W-1:0]   res_q;
	logic              done_q;
	logic [ROOT_W-1:0] root_q;

	logic              ge;
	logic [REM_W-1:0]  rem_sub;
	logic [DQ_W-1:0]   quo_nxt;
	logic [4:0]        sh;
	logic [OP_W-1:0]   one;
	logic [OP_W-1:0]   trial;
	logic              take;
	logic [OP_W-1:0]   res_nxt;

	always_comb begin
		ge      = rem_q >= {1'b0, div_q};
		rem_sub = ge ? (rem_q - {1'b0, div_q}) : rem_q;
		quo_nxt = {quo_q[DQ_W-2:0], ge};
		sh      = 5'd28 - {cnt_q[3:0], 1'b0};
		one     = OP_W'(1) << sh;
		trial   = res_q + one;
		take    = op_q >= trial;
		res_nxt = take ? ((res_q >> 1) + one) : (res_q >> 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= NM_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (st_q)
				NM_IDLE: begin
					if (nreq.start) begin
						st_q  <= NM_DIV;
						cnt_q <= '0;
					end
				end
				NM_DIV: begin
					if (cnt_q == 5'd28) begin
						st_q  <= NM_SQRT;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				NM_SQRT: begin
					if (cnt_q == 5'd14) begin
						st_q   <= NM_IDLE;
						done_q <= 1'b1;
					end else begin
						cnt_q <= cnt_q + 5'd1;
					end
				end
				default: st_q <= NM_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			NM_IDLE: begin
				rem_q <= REM_W'(nreq.sq);
				div_q <= nreq.nrm2;
				quo_q <= '0;
			end
			NM_DIV: begin
				rem_q <= {rem_sub[REM_W-2:0], 1'b0};
				quo_q <= quo_nxt;
				op_q  <= OP_W'(quo_nxt);
				res_q <= '0;
			end
			NM_SQRT: begin
				if (take) begin
					op_q <= op_q - trial;
				end
				res_q <= res_nxt;
				if (cnt_q == 5'd14) begin
					root_q <= res_nxt[ROOT_W-1:0];
				end
			end
			default: ;
		endcase
	end

	assign nrsp.done = done_q;
	assign nrsp.root = root_q;
endmodule

/* rtl/triangle_face_normal_unit.sv */
// A vertex write gives no result and leaves busy low; a face steps through store reads, the
// difference, the cross product, magnitudes and squaring on one shared 18x18 multiplier, the
// sum, then per component 29 divide and 15 square-root steps with a handoff, before strobing
// its result; a degenerate face goes from the magnitude step straight to the result.
// Throughput: one face at a time; busy stays high until the result strobe.
// Reset clears control and the fallback registers; the vertex store is not cleared.
// ----------------------------------------------------------------------------
// triangle_face_normal_unit
// Vertex store plus face unit-normal sequencer.
// ----------------------------------------------------------------------------
`include "triangle_face_normal_unit_assert.svh"

module triangle_face_normal_unit #(
	parameter int VERTEX_COUNT = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  tfn_pkg::req_t                     req,
	output logic                              result_valid,
	output tfn_pkg::result_t                  result,
	input  logic                              cfg_we,
	input  logic [tfn_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [tfn_pkg::COORD_W-1:0]       cfg_data
);
	import tfn_pkg::*;

	localparam int AW = $clog2(VERTEX_COUNT);
	localparam int EW = 17;

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_READ  = 4'd1;
	localparam logic [3:0] ST_DIFF  = 4'd2;
	localparam logic [3:0] ST_CROSS = 4'd3;
	localparam logic [3:0] ST_MAG   = 4'd4;
	localparam logic [3:0] ST_SQ    = 4'd5;
	localparam logic [3:0] ST_SUM   = 4'd6;
	localparam logic [3:0] ST_NORM  = 4'd7;
	localparam logic [3:0] ST_WAIT  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0] st_q;
	logic [3:0] cnt_q;
	logic [1:0] comp_q;

	logic [COORD_W-1:0] fb_x_q, fb_y_q, fb_z_q;

	logic [AW-1:0] addr_a_q, addr_b_q, addr_c_q;
	logic [2:0]    ok_q;

	logic signed [COORD_W-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q, cx_q, cy_q, cz_q;
	logic signed [EW-1:0] ux_q, uy_q, uz_q, vx_q, vy_q, vz_q;
	logic signed [34:0]   nx_q, ny_q, nz_q;
	logic [MAG_W-1:0]     mx_q, my_q, mz_q;
	logic [2:0]           neg_q;
	logic [SQ_W-1:0]      sqx_q, sqy_q, sqz_q;
	logic [NRM2_W-1:0]    nrm2_q;
	logic [ROOT_W-1:0]    qx_q, qy_q, qz_q;
	logic signed [35:0]   prod_q;

	logic    res_valid_q;
	result_t res_q;

	logic accept;
	assign accept = start && !busy;

	// ---- vertex store ----
	logic [EW-1:0]    slot_ext, ca_ext, cb_ext, cc_ext;
	logic             ram_we, ram_re;
	logic [AW-1:0]    ram_raddr;
	logic [VTX_W-1:0] ram_rdata;

	assign slot_ext = EW'(req.vertex_slot);
	assign ca_ext   = EW'(req.corner_a);
	assign cb_ext   = EW'(req.corner_b);
	assign cc_ext   = EW'(req.corner_c);
	assign ram_we   = accept && (req.operation == OP_WRITE) && (slot_ext < EW'(VERTEX_COUNT));
	assign ram_re   = (st_q == ST_READ) && (cnt_q < 4'd3);

	always_comb begin
		case (cnt_q[1:0])
			2'd0:    ram_raddr = addr_a_q;
			2'd1:    ram_raddr = addr_b_q;
			default: ram_raddr = addr_c_q;
		endcase
	end

	tfn_ram #(.WIDTH(VTX_W), .DEPTH(VERTEX_COUNT)) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_ext[AW-1:0]),
		.wdata ({req.coord_x, req.coord_y, req.coord_z}),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---- shared 18x18 multiplier ----
	logic signed [EW:0] mul_a, mul_b;
	sq_sel_t           iss, con;
	logic [MAG_W-1:0]  iss_mag;
	logic [SQ_W-1:0]   sq_term;

	assign iss = sq_map(cnt_q);
	assign con = sq_map(cnt_q - 4'd1);

	always_comb begin
		case (iss.comp)
			2'd0:    iss_mag = mx_q;
			2'd1:    iss_mag = my_q;
			default: iss_mag = mz_q;
		endcase
		mul_a = '0;
		mul_b = '0;
		if (st_q == ST_CROSS) begin
			case (cnt_q)
				4'd0: begin mul_a = (EW+1)'(uy_q); mul_b = (EW+1)'(vz_q); end
				4'd1: begin mul_a = (EW+1)'(uz_q); mul_b = (EW+1)'(vy_q); end
				4'd2: begin mul_a = (EW+1)'(uz_q); mul_b = (EW+1)'(vx_q); end
				4'd3: begin mul_a = (EW+1)'(ux_q); mul_b = (EW+1)'(vz_q); end
				4'd4: begin mul_a = (EW+1)'(ux_q); mul_b = (EW+1)'(vy_q); end
				4'd5: begin mul_a = (EW+1)'(uy_q); mul_b = (EW+1)'(vx_q); end
				default: ;
			endcase
		end else begin
			case (iss.part)
				2'd0: begin
					mul_a = {1'b0, iss_mag[16:0]};
					mul_b = {1'b0, iss_mag[16:0]};
				end
				2'd1: begin
					mul_a = {1'b0, iss_mag[33:17]};
					mul_b = {1'b0, iss_mag[16:0]};
				end
				default: begin
					mul_a = {1'b0, iss_mag[33:17]};
					mul_b = {1'b0, iss_mag[33:17]};
				end
			endcase
		end
		case (con.part)
			2'd0:    sq_term = SQ_W'(prod_q[33:0]);
			2'd1:    sq_term = SQ_W'(prod_q[33:0]) << 18;
			default: sq_term = SQ_W'(prod_q[33:0]) << 34;
		endcase
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	// ---- norm unit ----
	norm_req_t nreq;
	norm_rsp_t nrsp;

	always_comb begin
		nreq.start = (st_q == ST_NORM);
		nreq.nrm2  = nrm2_q;
		case (comp_q)
			2'd0:    nreq.sq = sqx_q;
			2'd1:    nreq.sq = sqy_q;
			default: nreq.sq = sqz_q;
		endcase
	end

	tfn_norm u_norm (
		.clk    (clk),
		.arst_n (arst_n),
		.nreq   (nreq),
		.nrsp   (nrsp)
	);

	// ---- sequencer ----
	logic all_zero;
	assign all_zero = (nx_q == '0) && (ny_q == '0) && (nz_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cnt_q       <= '0;
			comp_q      <= '0;
			res_valid_q <= 1'b0;
			fb_x_q      <= '0;
			fb_y_q      <= '0;
			fb_z_q      <= '0;
		end else begin
			res_valid_q <= 1'b0;
			if (cfg_we) begin
				case (cfg_index)
					CFG_FALLBACK_X: fb_x_q <= cfg_data;
					CFG_FALLBACK_Y: fb_y_q <= cfg_data;
					CFG_FALLBACK_Z: fb_z_q <= cfg_data;
					default: ;
				endcase
			end
			case (st_q)
				ST_IDLE: begin
					if (accept && req.operation == OP_FACE) begin
						st_q  <= ST_READ;
						cnt_q <= '0;
					end
				end
				ST_READ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd3) begin
						st_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					st_q  <= ST_CROSS;
					cnt_q <= '0;
				end
				ST_CROSS: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd6) begin
						st_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					cnt_q <= '0;
					st_q  <= all_zero ? ST_OUT : ST_SQ;
				end
				ST_SQ: begin
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd9) begin
						st_q <= ST_SUM;
					end
				end
				ST_SUM: begin
					comp_q <= '0;
					st_q   <= ST_NORM;
				end
				ST_NORM: st_q <= ST_WAIT;
				ST_WAIT: begin
					if (nrsp.done) begin
						if (comp_q == 2'd2) begin
							st_q <= ST_OUT;
						end else begin
							comp_q <= comp_q + 2'd1;
							st_q   <= ST_NORM;
						end
					end
				end
				ST_OUT: begin
					res_valid_q <= 1'b1;
					st_q        <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// ---- datapath registers ----
	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				addr_a_q <= ca_ext[AW-1:0];
				addr_b_q <= cb_ext[AW-1:0];
				addr_c_q <= cc_ext[AW-1:0];
				ok_q <= {cc_ext < EW'(VERTEX_COUNT), cb_ext < EW'(VERTEX_COUNT),
					ca_ext < EW'(VERTEX_COUNT)};
			end
			ST_READ: begin
				case (cnt_q)
					4'd1: {ax_q, ay_q, az_q} <= ok_q[0] ? ram_rdata : '0;
					4'd2: {bx_q, by_q, bz_q} <= ok_q[1] ? ram_rdata : '0;
					4'd3: {cx_q, cy_q, cz_q} <= ok_q[2] ? ram_rdata : '0;
					default: ;
				endcase
			end
			ST_DIFF: begin
				ux_q <= EW'(bx_q) - EW'(ax_q);
				uy_q <= EW'(by_q) - EW'(ay_q);
				uz_q <= EW'(bz_q) - EW'(az_q);
				vx_q <= EW'(cx_q) - EW'(ax_q);
				vy_q <= EW'(cy_q) - EW'(ay_q);
				vz_q <= EW'(cz_q) - EW'(az_q);
			end
			ST_CROSS: begin
				// product of step k is registered and lands in the cycle after it is issued
				case (cnt_q)
					4'd1: nx_q <= 35'(prod_q);
					4'd2: nx_q <= nx_q - 35'(prod_q);
					4'd3: ny_q <= 35'(prod_q);
					4'd4: ny_q <= ny_q - 35'(prod_q);
					4'd5: nz_q <= 35'(prod_q);
					4'd6: nz_q <= nz_q - 35'(prod_q);
					default: ;
				endcase
			end
			ST_MAG: begin
				mx_q  <= nx_q[34] ? MAG_W'(-nx_q) : MAG_W'(nx_q);
				my_q  <= ny_q[34] ? MAG_W'(-ny_q) : MAG_W'(ny_q);
				mz_q  <= nz_q[34] ? MAG_W'(-nz_q) : MAG_W'(nz_q);
				neg_q <= {nz_q[34], ny_q[34], nx_q[34]};
				sqx_q <= '0;
				sqy_q <= '0;
				sqz_q <= '0;
			end
			ST_SQ: begin
				if (cnt_q != 4'd0) begin
					case (con.comp)
						2'd0:    sqx_q <= sqx_q + sq_term;
						2'd1:    sqy_q <= sqy_q + sq_term;
						default: sqz_q <= sqz_q + sq_term;
					endcase
				end
			end
			ST_SUM: begin
				nrm2_q <= NRM2_W'(sqx_q) + NRM2_W'(sqy_q) + NRM2_W'(sqz_q);
			end
			ST_WAIT: begin
				if (nrsp.done) begin
					case (comp_q)
						2'd0:    qx_q <= nrsp.root;
						2'd1:    qy_q <= nrsp.root;
						default: qz_q <= nrsp.root;
					endcase
				end
			end
			ST_OUT: begin
				if (all_zero) begin
					res_q <= '{normal_x: fb_x_q, normal_y: fb_y_q, normal_z: fb_z_q,
						degenerate: 1'b1};
				end else begin
					res_q.normal_x   <= neg_q[0] ? -COORD_W'(qx_q) : COORD_W'(qx_q);
					res_q.normal_y   <= neg_q[1] ? -COORD_W'(qy_q) : COORD_W'(qy_q);
					res_q.normal_z   <= neg_q[2] ? -COORD_W'(qz_q) : COORD_W'(qz_q);
					res_q.degenerate <= 1'b0;
				end
			end
			default: ;
		endcase
	end

	assign busy         = (st_q != ST_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

	`TFN_ASSERT_IMP(a_result_idle, clk, arst_n, result_valid, !busy)
	`TFN_ASSERT_NXT(a_result_pulse, clk, arst_n, result_valid, !result_valid)
	`TFN_ASSERT_NXT(a_face_busy, clk, arst_n, accept && req.operation == OP_FACE, busy)
	`TFN_ASSERT_NXT(a_write_free, clk, arst_n, accept && req.operation == OP_WRITE, !busy)
	`TFN_ASSERT_IMP(a_done_wait, clk, arst_n, nrsp.done, st_q == ST_WAIT)
endmodule

/* sim/face_normal_checker.sv */
// ----------------------------------------------------------------------------
// face_normal_checker
// Watches the request, result and register channels of the face normal unit,
// keeps its own vertex store and fallback copy, predicts each face's Q1.14
// unit normal and compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module face_normal_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic                          busy,
	input  tfn_pkg::req_t                 req,
	input  logic                          result_valid,
	input  tfn_pkg::result_t              result,
	input  logic                          cfg_we,
	input  logic [tfn_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [tfn_pkg::COORD_W-1:0]   cfg_data,
	output int                            fail_count,
	output int                            pending,
	output int                            faces_done,
	output int                            degenerate_done
);
	import tfn_pkg::*;

	logic signed [COORD_W-1:0] vtx_x [1024];
	logic signed [COORD_W-1:0] vtx_y [1024];
	logic signed [COORD_W-1:0] vtx_z [1024];
	logic signed [COORD_W-1:0] fb_x, fb_y, fb_z;
	result_t normal_q [$];

	// greatest q with q*q*S <= n*n*2^28, signed back onto n
	function automatic logic [15:0] unit_component(input longint n, input logic [127:0] s);
		logic [127:0] mag, tgt, cand;
		logic [14:0] q;
		mag = (n < 0) ? 128'(-n) : 128'(n);
		tgt = (mag * mag) << 28;
		q = '0;
		for (int b = 14; b >= 0; b--) begin
			cand = 128'(q) | (128'd1 << b);
			if (s * cand * cand <= tgt)
				q = cand[14:0];
		end
		return (n < 0) ? 16'(-{1'b0, q}) : 16'({1'b0, q});
	endfunction

	function automatic result_t face_normal(input logic [IDX_W-1:0] a,
			input logic [IDX_W-1:0] b, input logic [IDX_W-1:0] c);
		longint ux, uy, uz, vx, vy, vz, nx, ny, nz;
		logic [127:0] s, mx, my, mz;
		result_t r;
		ux = longint'(vtx_x[b]) - longint'(vtx_x[a]);
		uy = longint'(vtx_y[b]) - longint'(vtx_y[a]);
		uz = longint'(vtx_z[b]) - longint'(vtx_z[a]);
		vx = longint'(vtx_x[c]) - longint'(vtx_x[a]);
		vy = longint'(vtx_y[c]) - longint'(vtx_y[a]);
		vz = longint'(vtx_z[c]) - longint'(vtx_z[a]);
		nx = uy * vz - uz * vy;
		ny = uz * vx - ux * vz;
		nz = ux * vy - uy * vx;
		if (nx == 0 && ny == 0 && nz == 0) begin
			r = '{normal_x: fb_x, normal_y: fb_y, normal_z: fb_z, degenerate: 1'b1};
		end else begin
			// squares reach 2^66, so square the magnitudes at full width
			mx = (nx < 0) ? 128'(-nx) : 128'(nx);
			my = (ny < 0) ? 128'(-ny) : 128'(ny);
			mz = (nz < 0) ? 128'(-nz) : 128'(nz);
			s = mx * mx + my * my + mz * mz;
			r.normal_x = unit_component(nx, s);
			r.normal_y = unit_component(ny, s);
			r.normal_z = unit_component(nz, s);
			r.degenerate = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		if (!arst_n) begin
			fb_x <= '0;
			fb_y <= '0;
			fb_z <= '0;
			normal_q.delete();
			fail_count <= 0;
			pending <= 0;
			faces_done <= 0;
			degenerate_done <= 0;
		end else begin
			if (result_valid) begin
				if (normal_q.size() == 0) begin
					fail_count <= fail_count + 1;
					if (fail_count < 10)
						$display("unexpected result %p", result);
				end else begin
					exp_r = normal_q.pop_front();
					faces_done <= faces_done + 1;
					if (result.degenerate)
						degenerate_done <= degenerate_done + 1;
					if (result !== exp_r) begin
						fail_count <= fail_count + 1;
						if (fail_count < 10)
							$display("normal mismatch: expected %p got %p", exp_r, result);
					end
				end
			end
			if (start && !busy) begin
				if (req.operation == OP_WRITE) begin
					vtx_x[req.vertex_slot] = req.coord_x;
					vtx_y[req.vertex_slot] = req.coord_y;
					vtx_z[req.vertex_slot] = req.coord_z;
				end else begin
					normal_q.push_back(face_normal(req.corner_a, req.corner_b, req.corner_c));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_FALLBACK_X: fb_x <= cfg_data;
					CFG_FALLBACK_Y: fb_y <= cfg_data;
					CFG_FALLBACK_Z: fb_z <= cfg_data;
					default: ;
				endcase
			end
			pending <= normal_q.size();
		end
	end

endmodule

/* sim/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives vertex writes and face requests into the face normal unit with random
// gaps, steps the fallback registers through several settings, and reports
// the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module testbench;
	import tfn_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic result_valid;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COORD_W-1:0] cfg_data;
	int fail_count, pending, faces_done, degenerate_done;
	int idle_cycles;
	int written_slots [$];
	int request_count;

	triangle_face_normal_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	face_normal_checker i_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .req(req),
		.result_valid(result_valid), .result(result),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending(pending),
		.faces_done(faces_done), .degenerate_done(degenerate_done)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// no-progress watchdog
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic req_t random_fill();
		logic [95:0] raw;
		req_t r;
		raw = {$urandom, $urandom, $urandom};
		r = raw[$bits(req_t)-1:0];
		return r;
	endfunction

	// hold the request until accepted, then leave a random gap
	task automatic send(input req_t r, input bit no_gap);
		int gap;
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		request_count++;
		if (r.operation == OP_WRITE)
			written_slots.push_back(int'(r.vertex_slot));
		gap = 0;
		if (!no_gap) begin
			case ($urandom_range(9))
				0, 1, 2, 3, 4, 5: gap = 0;
				6, 7, 8: gap = $urandom_range(3, 1);
				default: gap = $urandom_range(60, 10);
			endcase
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic write_vertex(input int slot, input int x, input int y, input int z);
		req_t r;
		r = random_fill();
		r.operation = OP_WRITE;
		r.vertex_slot = slot[IDX_W-1:0];
		r.coord_x = x[15:0];
		r.coord_y = y[15:0];
		r.coord_z = z[15:0];
		send(r, 1'b0);
	endtask

	task automatic face(input int a, input int b, input int c);
		req_t r;
		r = random_fill();
		r.operation = OP_FACE;
		r.corner_a = a[IDX_W-1:0];
		r.corner_b = b[IDX_W-1:0];
		r.corner_c = c[IDX_W-1:0];
		send(r, 1'b0);
	endtask

	// registers change only with the unit drained and idle
	task automatic set_fallback(input int x, input int y, input int z);
		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		@(posedge clk);
		while (busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_FALLBACK_X; cfg_data <= x[15:0]; @(posedge clk);
		cfg_index <= CFG_FALLBACK_Y; cfg_data <= y[15:0]; @(posedge clk);
		cfg_index <= CFG_FALLBACK_Z; cfg_data <= z[15:0]; @(posedge clk);
		cfg_index <= 2'd3; cfg_data <= 16'($urandom); @(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	function automatic int rand_coord(input bit tiny);
		if (tiny)
			return $urandom_range(16) - 8;
		return int'($urandom_range(65535)) - 32768;
	endfunction

	task automatic random_phase(input int count);
		int pick, a, b, c;
		bit tiny;
		for (int i = 0; i < count; i++) begin
			pick = $urandom_range(99);
			if (pick < 40) begin
				tiny = ($urandom_range(3) == 0);
				write_vertex($urandom_range(1023), rand_coord(tiny), rand_coord(tiny),
					rand_coord(tiny));
			end else begin
				a = written_slots[$urandom_range(written_slots.size() - 1)];
				b = written_slots[$urandom_range(written_slots.size() - 1)];
				c = written_slots[$urandom_range(written_slots.size() - 1)];
				// repeated corner gives a degenerate face
				if (pick < 48)
					c = ($urandom_range(1)) ? a : b;
				face(a, b, c);
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_cycles = 0;
		request_count = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// degenerate face with registers still at reset
		write_vertex(0, -32768, -32768, -32768);
		write_vertex(1023, 32767, -32768, -32768);
		write_vertex(512, -32768, 32767, -32768);
		face(0, 1023, 512);
		face(0, 0, 0);
		set_fallback(16384, -16384, 0);
		// largest cross product, all-axis extremes
		write_vertex(1, 32767, 32767, -32768);
		write_vertex(2, -32768, 32767, 32767);
		face(0, 1, 2);
		face(1023, 2, 1);
		// collinear points
		write_vertex(3, 0, 0, 0);
		write_vertex(4, 1, 1, 1);
		write_vertex(5, 2, 2, 2);
		face(3, 4, 5);
		face(5, 5, 3);
		// unit axes and a tiny face
		write_vertex(6, 1, 0, 0);
		write_vertex(7, 0, 1, 0);
		face(3, 6, 7);
		face(3, 7, 6);
		write_vertex(341, 0, 0, 1);
		face(6, 7, 341);
		face(4, 6, 341);

		random_phase(300);
		set_fallback(-16384, 16384, -16384);
		random_phase(300);
		set_fallback(int'($urandom_range(32768)) - 16384,
			int'($urandom_range(32768)) - 16384, int'($urandom_range(32768)) - 16384);
		random_phase(300);
		set_fallback(0, 0, 16384);
		random_phase(330);

		start <= 1'b0;
		@(posedge clk);
		wait (pending == 0);
		repeat (200) @(posedge clk);
		$display("%0d requests sent, %0d face normals checked (%0d degenerate)",
			request_count, faces_done, degenerate_done);
		$display("fallback registers stepped through four settings incl. both extremes");
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
